>>> rtl/owtsm_pkg.sv
// Shared types and constants for the single-wire bus master.
// Holds phase and step codes, the configuration and state structs, and the result word.
// No dependencies.
`default_nettype none

package owtsm_pkg;

   // request codes
   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_RESET = 3'd1;
   localparam logic [2:0] REQ_WRITE = 3'd2;
   localparam logic [2:0] REQ_READ  = 3'd3;
   localparam logic [2:0] REQ_TEMP  = 3'd4;

   // configuration register indexes
   localparam logic [7:0] CSR_IDLE      = 8'd0;
   localparam logic [7:0] CSR_RST_LOW   = 8'd1;
   localparam logic [7:0] CSR_PRES_SAMP = 8'd2;
   localparam logic [7:0] CSR_RST_REC   = 8'd3;
   localparam logic [7:0] CSR_WR_LOW    = 8'd4;
   localparam logic [7:0] CSR_SLOT_TAIL = 8'd5;
   localparam logic [7:0] CSR_RD_LOW    = 8'd6;
   localparam logic [7:0] CSR_RD_SAMP   = 8'd7;

   // sequence steps: temperature read runs RST1 through RST3
   localparam logic [3:0] STEP_RST1  = 4'd0;
   localparam logic [3:0] STEP_SKIP1 = 4'd1;
   localparam logic [3:0] STEP_CONVT = 4'd2;
   localparam logic [3:0] STEP_WAIT  = 4'd3;
   localparam logic [3:0] STEP_RST2  = 4'd4;
   localparam logic [3:0] STEP_SKIP2 = 4'd5;
   localparam logic [3:0] STEP_RDSP  = 4'd6;
   localparam logic [3:0] STEP_RDLO  = 4'd7;
   localparam logic [3:0] STEP_RDHI  = 4'd8;
   localparam logic [3:0] STEP_RST3  = 4'd9;
   localparam logic [3:0] STEP_RESET = 4'd10;
   localparam logic [3:0] STEP_WRITE = 4'd11;
   localparam logic [3:0] STEP_READ  = 4'd12;

   // bus command bytes
   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_PAD = 8'hBE;

   localparam logic [15:0] PRESENCE_TIMEOUT = 16'd2000;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_RPRE   = 4'd1,
      PH_RLOW   = 4'd2,
      PH_RSAMP  = 4'd3,
      PH_RWAITP = 4'd4,
      PH_RREC   = 4'd5,
      PH_WPRE   = 4'd6,
      PH_WLOW   = 4'd7,
      PH_WTAIL  = 4'd8,
      PH_BPRE   = 4'd9,
      PH_BLOW   = 4'd10,
      PH_BSAMP  = 4'd11,
      PH_BTAIL  = 4'd12,
      PH_CONV   = 4'd13
   } phase_type;

   typedef struct packed {
      logic [15:0] idle_ticks;
      logic [15:0] reset_low_ticks;
      logic [15:0] presence_sample_ticks;
      logic [15:0] reset_recovery_ticks;
      logic [15:0] write_low_ticks;
      logic [15:0] slot_tail_ticks;
      logic [15:0] read_low_ticks;
      logic [15:0] read_sample_ticks;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] tick;
      logic [2:0]  bit_idx;
      logic [7:0]  shift;
      logic [3:0]  step;
      logic [7:0]  low_hold;
      logic [1:0]  pflags;     // bit 0 present, bit 1 timeout
      logic [16:0] result;     // bit 16 sign, 15..0 magnitude
      logic [7:0]  last_read;
   } st_type;

   localparam st_type ST_RESET = '{PH_IDLE, 16'd0, 3'd0, 8'd0, 4'd0, 8'd0, 2'd0, 17'd0, 8'd0};

   typedef struct packed {
      logic        drive_low;
      logic        busy_res;
      logic        done_res;
      logic        rejected;
      logic        device_present;
      logic        presence_timeout;
      logic [7:0]  read_data;
      logic [15:0] temp_magnitude;
      logic        temp_negative;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/owtsm_csr.sv
// Timing configuration registers for the single-wire bus master.
// Depends on owtsm_pkg (cfg_type, register indexes).
`default_nettype none

module owtsm_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_en,
   input  wire logic [7:0]       csr_index,
   input  wire logic [15:0]      csr_data,
   output owtsm_pkg::cfg_type    cfg
);
   import owtsm_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // write decode; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_IDLE:      cfg_in.idle_ticks            = csr_data;
            CSR_RST_LOW:   cfg_in.reset_low_ticks       = csr_data;
            CSR_PRES_SAMP: cfg_in.presence_sample_ticks = csr_data;
            CSR_RST_REC:   cfg_in.reset_recovery_ticks  = csr_data;
            CSR_WR_LOW:    cfg_in.write_low_ticks       = csr_data;
            CSR_SLOT_TAIL: cfg_in.slot_tail_ticks       = csr_data;
            CSR_RD_LOW:    cfg_in.read_low_ticks        = csr_data;
            CSR_RD_SAMP:   cfg_in.read_sample_ticks     = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{16'd1000, 16'd480, 16'd60, 16'd240, 16'd15, 16'd45, 16'd1, 16'd13};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/owtsm_core.sv
// Per-tick sequencer of the single-wire bus master: phase machine, slot counter,
// shift byte and held results. Depends on owtsm_pkg.
`default_nettype none

module owtsm_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [2:0]       req_type,
   input  wire logic [7:0]       req_write_data,
   input  wire logic             req_line_level,
   input  wire owtsm_pkg::cfg_type cfg,
   output owtsm_pkg::rsp_type    rsp_word
);
   import owtsm_pkg::*;

   st_type st_ff, st_in;

   // tick count has reached the phase length (zero counts as one tick)
   function automatic logic elapsed(input logic [15:0] tick, input logic [15:0] dur);
      elapsed = ({1'b0, tick} + 17'd1) >= {1'b0, dur};
   endfunction

   // start one step of a command sequence
   function automatic st_type begin_op(input st_type s, input logic [3:0] step,
                                       input logic [7:0] data);
      st_type r;
      r         = s;
      r.step    = step;
      r.bit_idx = 3'd0;
      r.tick    = 16'd0;
      case (step) inside
         STEP_RST1, STEP_RST2, STEP_RST3, STEP_RESET: begin
            r.pflags = 2'd0;
            r.phase  = PH_RPRE;
         end
         STEP_SKIP1, STEP_SKIP2: begin
            r.shift = CMD_SKIP_ROM;
            r.phase = PH_WPRE;
         end
         STEP_CONVT: begin
            r.shift = CMD_CONVERT;
            r.phase = PH_WPRE;
         end
         STEP_RDSP: begin
            r.shift = CMD_READ_PAD;
            r.phase = PH_WPRE;
         end
         STEP_WRITE: begin
            r.shift = data;
            r.phase = PH_WPRE;
         end
         STEP_WAIT: r.phase = PH_CONV;
         STEP_RDLO, STEP_RDHI, STEP_READ: begin
            r.shift = 8'd0;
            r.phase = PH_BPRE;
         end
         default: r.phase = PH_IDLE;
      endcase
      return r;
   endfunction

   // close the current step: capture read bytes, then chain or go idle
   function automatic st_type finish_op(input st_type s);
      st_type      r;
      logic [15:0] raw;
      r   = s;
      raw = {s.shift, s.low_hold};
      if (s.step == STEP_RDLO) begin
         r.low_hold = s.shift;
      end else if (s.step == STEP_RDHI) begin
         if (s.shift[7]) r.result = {1'b1, ~raw + 16'd1};
         else            r.result = {1'b0, raw};
      end else if (s.step == STEP_READ) begin
         r.last_read = s.shift;
      end
      if (s.step < STEP_RST3) begin
         r = begin_op(r, s.step + 4'd1, 8'd0);
      end else begin
         r.phase = PH_IDLE;
         r.tick  = 16'd0;
      end
      return r;
   endfunction

   // next state and result for one tick
   always_comb begin
      st_type s;
      logic   drive, done, rej, adv;
      s     = st_ff;
      drive = 1'b0;
      done  = 1'b0;
      rej   = 1'b0;
      adv   = 1'b0;

      // command intake
      if (s.phase != PH_IDLE) begin
         rej = req_type != REQ_TICK;
      end else begin
         case (req_type)
            REQ_RESET: s = begin_op(s, STEP_RESET, 8'd0);
            REQ_WRITE: s = begin_op(s, STEP_WRITE, req_write_data);
            REQ_READ:  s = begin_op(s, STEP_READ, 8'd0);
            REQ_TEMP:  s = begin_op(s, STEP_RST1, 8'd0);
            default: ;
         endcase
      end

      // phase work for this tick
      unique case (s.phase)
         PH_IDLE: ;
         PH_RPRE: begin
            if (elapsed(s.tick, cfg.idle_ticks)) begin
               s.phase = PH_RLOW; s.tick = 16'd0; adv = 1'b1;
            end
         end
         PH_RLOW: begin
            drive = 1'b1;
            if (elapsed(s.tick, cfg.reset_low_ticks)) begin
               s.phase = PH_RSAMP; s.tick = 16'd0; adv = 1'b1;
            end
         end
         PH_RSAMP: begin
            if (elapsed(s.tick, cfg.presence_sample_ticks)) begin
               s.pflags = {1'b0, ~req_line_level};
               s.phase  = PH_RWAITP; s.tick = 16'd0; adv = 1'b1;
            end
         end
         PH_RWAITP: begin
            if (!req_line_level) begin
               s.phase = PH_RREC; s.tick = 16'd0; adv = 1'b1;
            end else if (elapsed(s.tick, PRESENCE_TIMEOUT)) begin
               s.pflags[1] = 1'b1;
               s.phase = PH_IDLE; s.tick = 16'd0; adv = 1'b1; done = 1'b1;
            end
         end
         PH_RREC: begin
            if (elapsed(s.tick, cfg.reset_recovery_ticks)) begin
               done = s.step >= STEP_RST3;
               s    = finish_op(s);
               adv  = 1'b1;
            end
         end
         PH_WPRE: begin
            if (elapsed(s.tick, cfg.idle_ticks)) begin
               s.phase = PH_WLOW; s.tick = 16'd0; adv = 1'b1;
            end
         end
         PH_WLOW: begin
            drive = 1'b1;
            if (elapsed(s.tick, cfg.write_low_ticks)) begin
               s.phase = PH_WTAIL; s.tick = 16'd0; adv = 1'b1;
            end
         end
         PH_WTAIL: begin
            drive = ~s.shift[0];
            if (elapsed(s.tick, cfg.slot_tail_ticks)) begin
               s.shift = {1'b0, s.shift[7:1]};
               adv     = 1'b1;
               if (s.bit_idx == 3'd7) begin
                  done = s.step >= STEP_RST3;
                  s    = finish_op(s);
               end else begin
                  s.bit_idx = s.bit_idx + 3'd1;
                  s.phase   = PH_WPRE; s.tick = 16'd0;
               end
            end
         end
         PH_BPRE: begin
            if (elapsed(s.tick, cfg.idle_ticks)) begin
               s.phase = PH_BLOW; s.tick = 16'd0; adv = 1'b1;
            end
         end
         PH_BLOW: begin
            drive = 1'b1;
            if (elapsed(s.tick, cfg.read_low_ticks)) begin
               s.phase = PH_BSAMP; s.tick = 16'd0; adv = 1'b1;
            end
         end
         PH_BSAMP: begin
            if (elapsed(s.tick, cfg.read_sample_ticks)) begin
               s.shift = {req_line_level, s.shift[7:1]};
               s.phase = PH_BTAIL; s.tick = 16'd0; adv = 1'b1;
            end
         end
         PH_BTAIL: begin
            if (elapsed(s.tick, cfg.slot_tail_ticks)) begin
               adv = 1'b1;
               if (s.bit_idx == 3'd7) begin
                  done = s.step >= STEP_RST3;
                  s    = finish_op(s);
               end else begin
                  s.bit_idx = s.bit_idx + 3'd1;
                  s.phase   = PH_BLOW; s.tick = 16'd0;
               end
            end
         end
         PH_CONV: begin
            if (elapsed(s.tick, cfg.idle_ticks)) begin
               done = s.step >= STEP_RST3;
               s    = finish_op(s);
               adv  = 1'b1;
            end
         end
         default: begin
            s.phase = PH_IDLE;
            adv     = 1'b1;
         end
      endcase

      if (!adv) s.tick = s.tick + 16'd1;

      st_in                     = s;
      rsp_word.drive_low        = drive;
      rsp_word.busy_res         = s.phase != PH_IDLE;
      rsp_word.done_res         = done;
      rsp_word.rejected         = rej;
      rsp_word.device_present   = s.pflags[0];
      rsp_word.presence_timeout = s.pflags[1];
      rsp_word.read_data        = s.last_read;
      rsp_word.temp_magnitude   = s.result[15:0];
      rsp_word.temp_negative    = s.result[16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_RESET;
      end else if (accept) begin
         st_ff <= st_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/owtsm_skid.sv
// Two-entry result buffer (output register plus skid register) for the bus master.
// Depends on owtsm_pkg (rsp_type).
`default_nettype none

module owtsm_skid (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire owtsm_pkg::rsp_type push_word,
   input  wire logic             rsp_stall,
   output logic                  rsp_valid,
   output owtsm_pkg::rsp_type    rsp_word,
   output logic                  full
);
   import owtsm_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    take;

   assign take = main_valid_ff && !rsp_stall;

   // drain on take, then load the pushed word into the first free slot
   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = 1'b0;
         end
      end
      if (push) begin
         if (!main_valid_in) begin
            main_valid_in = 1'b1;
            main_in       = push_word;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_word  = main_ff;
   assign full      = skid_valid_ff;

endmodule

`default_nettype wire

>>> rtl/one_wire_temp_sensor_master.sv
// Single-wire bus master with temperature read sequence, top level.
// Depends on owtsm_pkg, owtsm_csr, owtsm_core and owtsm_skid.
//
// Usage:
//  - Each req word is one bus tick (nominally 1 us): req_type carries an optional
//    command (reset, write byte, read byte, temperature read), req_line_level the
//    sampled bus line. Every accepted word yields exactly one rsp word.
//  - rsp_drive_low is the line drive for that tick; the held fields (presence,
//    read_data, temperature) keep their value until a later command updates them.
//  - Commands arriving while busy are dropped and flagged with rsp_rejected.
//  - The rsp word of an accepted req word is registered in the output buffer.
//    Throughput: one word per cycle while req_stall is low; the per-tick phase
//    machine and its 16-bit slot counter update combinationally from the state register.
//  - The rsp side has an output register plus a skid register; req_stall rises
//    only once both hold a word, i.e. after the receiver has stalled.
//  - Reset (synchronous) sets the sequencer idle, clears held results, empties
//    the output buffer and loads the default slot timings.
//  - Write timing registers through csr_* only while idle; the block does not check.
`default_nettype none

module one_wire_temp_sensor_master (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [7:0]  req_write_data,
   input  wire logic        req_line_level,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_drive_low,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic             rsp_rejected,
   output logic             rsp_device_present,
   output logic             rsp_presence_timeout,
   output logic [7:0]       rsp_read_data,
   output logic [15:0]      rsp_temp_magnitude,
   output logic             rsp_temp_negative,
   // configuration
   input  wire logic        csr_write_en,
   input  wire logic [7:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import owtsm_pkg::*;

   cfg_type cfg;
   rsp_type core_word;
   rsp_type out_word;
   logic    accept;
   logic    buf_full;

   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   owtsm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   owtsm_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_type       (req_type),
      .req_write_data (req_write_data),
      .req_line_level (req_line_level),
      .cfg            (cfg),
      .rsp_word       (core_word)
   );

   owtsm_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_word (core_word),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (out_word),
      .full      (buf_full)
   );

   assign rsp_drive_low        = out_word.drive_low;
   assign rsp_busy_res         = out_word.busy_res;
   assign rsp_done_res         = out_word.done_res;
   assign rsp_rejected         = out_word.rejected;
   assign rsp_device_present   = out_word.device_present;
   assign rsp_presence_timeout = out_word.presence_timeout;
   assign rsp_read_data        = out_word.read_data;
   assign rsp_temp_magnitude   = out_word.temp_magnitude;
   assign rsp_temp_negative    = out_word.temp_negative;

   // a full buffer always has a word on the output
   a_stall_has_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall high with no rsp word pending");

   // a completed command always leaves the sequencer idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> !rsp_busy_res)
      else $error("done reported while still busy");

   // a negative reading never has a zero magnitude
   a_neg_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_temp_negative) |-> (rsp_temp_magnitude != 16'd0))
      else $error("negative temperature with zero magnitude");

endmodule

`default_nettype wire

>>> dv/one_wire_temp_sensor_master_test.sv
// Self-checking testbench for the single-wire bus master: tick streams with bus device
// emulation, an in-line predictor of every rsp word, random idling and several timings.
// Depends on owtsm_pkg and one_wire_temp_sensor_master.
`default_nettype none

module one_wire_temp_sensor_master_test;
   timeunit 1ns;
   timeprecision 1ps;

   import owtsm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_WORDS = 200;

   // request codes the block treats as plain ticks while idle
   localparam logic [2:0] REQ_SPARE_A = 3'd5;
   localparam logic [2:0] REQ_SPARE_C = 3'd7;

   // register indexes past the last timing register
   localparam logic [7:0] CSR_UNUSED_LO = 8'd8;
   localparam logic [7:0] CSR_UNUSED_HI = 8'hFF;

   // how the emulated device answers on the line
   typedef enum logic [1:0] {
      DEV_PRESENT,
      DEV_ABSENT
   } dev_mode_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic       line;
   } tick_word_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] ticks;
      logic [2:0]  bit_idx;
      logic [7:0]  shreg;
      logic [3:0]  step;
      logic [7:0]  lo_hold;
      logic [1:0]  flags;      // bit 0 present, bit 1 timeout
      logic [16:0] temp;       // bit 16 sign
      logic [7:0]  last_byte;
   } bus_model_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_type = REQ_TICK;
   logic [7:0]  req_write_data = 8'd0;
   logic        req_line_level = 1'b1;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_drive_low;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic        rsp_rejected;
   logic        rsp_device_present;
   logic        rsp_presence_timeout;
   logic [7:0]  rsp_read_data;
   logic [15:0] rsp_temp_magnitude;
   logic        rsp_temp_negative;
   logic        csr_write_en = 1'b0;
   logic [7:0]  csr_index = CSR_IDLE;
   logic [15:0] csr_data = 16'd0;

   tick_word_type tick_q[$];
   rsp_type       predicted_rsp[$];
   cfg_type       timing;
   bus_model_type chk_state;
   bus_model_type plan_state;
   tick_word_type cur_word;
   rsp_type       next_rsp;
   rsp_type       want;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            pushed = 0;
   int            accepted = 0;
   int            error_count = 0;
   int            cycle_count = 0;

   one_wire_temp_sensor_master uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_write_data       (req_write_data),
      .req_line_level       (req_line_level),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_drive_low        (rsp_drive_low),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_done_res         (rsp_done_res),
      .rsp_rejected         (rsp_rejected),
      .rsp_device_present   (rsp_device_present),
      .rsp_presence_timeout (rsp_presence_timeout),
      .rsp_read_data        (rsp_read_data),
      .rsp_temp_magnitude   (rsp_temp_magnitude),
      .rsp_temp_negative    (rsp_temp_negative),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------- predictor ----------------

   // a phase set to N lasts N ticks, zero lasts one
   function automatic logic slot_over(logic [15:0] cnt, logic [15:0] dur);
      return ({1'b0, cnt} + 17'd1) >= {1'b0, dur};
   endfunction

   function automatic void enter(inout bus_model_type s, input phase_type p);
      s.phase = p;
      s.ticks = 16'd0;
   endfunction

   function automatic void start_step(inout bus_model_type s, input logic [3:0] step,
                                      input logic [7:0] data);
      s.step = step;
      s.bit_idx = 3'd0;
      case (step)
         STEP_RST1, STEP_RST2, STEP_RST3, STEP_RESET: begin
            s.flags = 2'd0;
            enter(s, PH_RPRE);
         end
         STEP_SKIP1, STEP_SKIP2: begin
            s.shreg = CMD_SKIP_ROM;
            enter(s, PH_WPRE);
         end
         STEP_CONVT: begin
            s.shreg = CMD_CONVERT;
            enter(s, PH_WPRE);
         end
         STEP_RDSP: begin
            s.shreg = CMD_READ_PAD;
            enter(s, PH_WPRE);
         end
         STEP_WRITE: begin
            s.shreg = data;
            enter(s, PH_WPRE);
         end
         STEP_WAIT: enter(s, PH_CONV);
         STEP_RDLO, STEP_RDHI, STEP_READ: begin
            s.shreg = 8'd0;
            enter(s, PH_BPRE);
         end
         default: enter(s, PH_IDLE);
      endcase
   endfunction

   // close the current step; done is set when the whole command has ended
   function automatic void end_step(inout bus_model_type s, output logic done);
      logic [15:0] raw;
      raw = {s.shreg, s.lo_hold};
      if (s.step == STEP_RDLO) begin
         s.lo_hold = s.shreg;
      end else if (s.step == STEP_RDHI) begin
         if (s.shreg[7]) s.temp = {1'b1, (~raw + 16'd1)};
         else s.temp = {1'b0, raw};
      end else if (s.step == STEP_READ) begin
         s.last_byte = s.shreg;
      end
      if (s.step < STEP_RST3) begin
         start_step(s, s.step + 4'd1, 8'd0);
         done = 1'b0;
      end else begin
         enter(s, PH_IDLE);
         done = 1'b1;
      end
   endfunction

   // one bus tick: state update and the rsp word it yields
   function automatic void bus_tick(inout bus_model_type s, input cfg_type c,
                                    input logic [2:0] kind,
                                    input logic [7:0] data, input logic line,
                                    output rsp_type r);
      logic drive;
      logic done;
      logic rej;
      logic adv;
      drive = 1'b0;
      done = 1'b0;
      rej = 1'b0;
      adv = 1'b0;
      if (s.phase != PH_IDLE) begin
         rej = (kind != REQ_TICK);
      end else begin
         case (kind)
            REQ_RESET: start_step(s, STEP_RESET, 8'd0);
            REQ_WRITE: start_step(s, STEP_WRITE, data);
            REQ_READ:  start_step(s, STEP_READ, 8'd0);
            REQ_TEMP:  start_step(s, STEP_RST1, 8'd0);
            default: ;
         endcase
      end

      case (s.phase)
         PH_RPRE: if (slot_over(s.ticks, c.idle_ticks)) begin
            enter(s, PH_RLOW);
            adv = 1'b1;
         end
         PH_RLOW: begin
            drive = 1'b1;
            if (slot_over(s.ticks, c.reset_low_ticks)) begin
               enter(s, PH_RSAMP);
               adv = 1'b1;
            end
         end
         PH_RSAMP: if (slot_over(s.ticks, c.presence_sample_ticks)) begin
            s.flags = line ? 2'd0 : 2'd1;
            enter(s, PH_RWAITP);
            adv = 1'b1;
         end
         PH_RWAITP: begin
            if (!line) begin
               enter(s, PH_RREC);
               adv = 1'b1;
            end else if (slot_over(s.ticks, PRESENCE_TIMEOUT)) begin
               // no presence pulse: abort the whole command
               s.flags[1] = 1'b1;
               enter(s, PH_IDLE);
               adv = 1'b1;
               done = 1'b1;
            end
         end
         PH_RREC: if (slot_over(s.ticks, c.reset_recovery_ticks)) begin
            end_step(s, done);
            adv = 1'b1;
         end
         PH_WPRE: if (slot_over(s.ticks, c.idle_ticks)) begin
            enter(s, PH_WLOW);
            adv = 1'b1;
         end
         PH_WLOW: begin
            drive = 1'b1;
            if (slot_over(s.ticks, c.write_low_ticks)) begin
               enter(s, PH_WTAIL);
               adv = 1'b1;
            end
         end
         PH_WTAIL: begin
            drive = !s.shreg[0];
            if (slot_over(s.ticks, c.slot_tail_ticks)) begin
               s.shreg = s.shreg >> 1;
               adv = 1'b1;
               if (s.bit_idx == 3'd7) begin
                  end_step(s, done);
               end else begin
                  s.bit_idx = s.bit_idx + 3'd1;
                  enter(s, PH_WPRE);
               end
            end
         end
         PH_BPRE: if (slot_over(s.ticks, c.idle_ticks)) begin
            enter(s, PH_BLOW);
            adv = 1'b1;
         end
         PH_BLOW: begin
            drive = 1'b1;
            if (slot_over(s.ticks, c.read_low_ticks)) begin
               enter(s, PH_BSAMP);
               adv = 1'b1;
            end
         end
         PH_BSAMP: if (slot_over(s.ticks, c.read_sample_ticks)) begin
            s.shreg = {line, s.shreg[7:1]};
            enter(s, PH_BTAIL);
            adv = 1'b1;
         end
         PH_BTAIL: if (slot_over(s.ticks, c.slot_tail_ticks)) begin
            adv = 1'b1;
            if (s.bit_idx == 3'd7) begin
               end_step(s, done);
            end else begin
               s.bit_idx = s.bit_idx + 3'd1;
               enter(s, PH_BLOW);
            end
         end
         PH_CONV: if (slot_over(s.ticks, c.idle_ticks)) begin
            end_step(s, done);
            adv = 1'b1;
         end
         default: begin
            s.phase = PH_IDLE;
            adv = 1'b1;
         end
      endcase
      if (!adv) s.ticks = s.ticks + 16'd1;

      r.drive_low = drive;
      r.busy_res = (s.phase != PH_IDLE);
      r.done_res = done;
      r.rejected = rej;
      r.device_present = s.flags[0];
      r.presence_timeout = s.flags[1];
      r.read_data = s.last_byte;
      r.temp_magnitude = s.temp[15:0];
      r.temp_negative = s.temp[16];
   endfunction

   function automatic void set_timing(logic [7:0] idx, logic [15:0] val);
      case (idx)
         CSR_IDLE:      timing.idle_ticks = val;
         CSR_RST_LOW:   timing.reset_low_ticks = val;
         CSR_PRES_SAMP: timing.presence_sample_ticks = val;
         CSR_RST_REC:   timing.reset_recovery_ticks = val;
         CSR_WR_LOW:    timing.write_low_ticks = val;
         CSR_SLOT_TAIL: timing.slot_tail_ticks = val;
         CSR_RD_LOW:    timing.read_low_ticks = val;
         CSR_RD_SAMP:   timing.read_sample_ticks = val;
         default: ;
      endcase
   endfunction

   // line level the emulated device puts on the bus during the planned phase
   function automatic logic line_for(bus_model_type s, dev_mode_type mode,
                                     logic [15:0] target);
      logic absent;
      absent = (mode == DEV_ABSENT);
      case (s.phase)
         PH_RSAMP:  return absent ? 1'b1 : ($urandom_range(3) == 0);
         PH_RWAITP: return absent ? 1'b1 : 1'($urandom_range(1));
         PH_BSAMP:  return (s.step == STEP_RDHI) ? target[8 + s.bit_idx] : target[s.bit_idx];
         default:   return 1'($urandom_range(1));
      endcase
   endfunction

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            bus_tick(chk_state, timing, req_type, req_write_data, req_line_level, next_rsp);
            predicted_rsp.push_back(next_rsp);
            accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_word = tick_q.pop_front();
               req_valid <= 1'b1;
               req_type <= cur_word.kind;
               req_write_data <= cur_word.data;
               req_line_level <= cur_word.line;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------

   task automatic compare_field(input string name, input logic [15:0] exp_val,
                                input logic [15:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp.size() == 0) begin
               $error("rsp word with nothing pending");
               error_count++;
            end else begin
               want = predicted_rsp.pop_front();
               compare_field("drive_low", 16'(want.drive_low), 16'(rsp_drive_low));
               compare_field("busy_res", 16'(want.busy_res), 16'(rsp_busy_res));
               compare_field("done_res", 16'(want.done_res), 16'(rsp_done_res));
               compare_field("rejected", 16'(want.rejected), 16'(rsp_rejected));
               compare_field("device_present", 16'(want.device_present),
                             16'(rsp_device_present));
               compare_field("presence_timeout", 16'(want.presence_timeout),
                             16'(rsp_presence_timeout));
               compare_field("read_data", 16'(want.read_data), 16'(rsp_read_data));
               compare_field("temp_magnitude", want.temp_magnitude, rsp_temp_magnitude);
               compare_field("temp_negative", 16'(want.temp_negative),
                             16'(rsp_temp_negative));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------- stimulus ----------------

   task automatic push_word(input logic [2:0] kind, input logic [7:0] data, input logic line);
      rsp_type scratch;
      bus_tick(plan_state, timing, kind, data, line, scratch);
      tick_q.push_back({kind, data, line});
      pushed++;
   endtask

   // issue a command and keep ticking until the planned sequence ends
   task automatic run_cmd(input logic [2:0] kind, input logic [7:0] data,
                          input dev_mode_type mode,
                          input logic [15:0] target, input int reject_pct);
      logic ln;
      push_word(kind, data, 1'($urandom_range(1)));
      while (plan_state.phase != PH_IDLE) begin
         ln = line_for(plan_state, mode, target);
         if ($urandom_range(99) < reject_pct)
            push_word(3'($urandom_range(REQ_SPARE_C, REQ_RESET)), 8'($urandom), ln);
         else
            push_word(REQ_TICK, 8'($urandom), ln);
      end
   endtask

   task automatic idle_word();
      logic [2:0] kind;
      kind = 3'($urandom_range(REQ_SPARE_C, REQ_SPARE_A));
      if ($urandom_range(1)) kind = REQ_TICK;
      push_word(kind, 8'($urandom), 1'($urandom_range(1)));
   endtask

   // wait until every word is taken and every rsp word is back
   task automatic wait_drained();
      while (accepted != pushed || predicted_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      set_timing(idx, val);
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic load_timing(input logic [15:0] idle, input logic [15:0] rlow,
                              input logic [15:0] psamp, input logic [15:0] rrec,
                              input logic [15:0] wlow, input logic [15:0] tail,
                              input logic [15:0] rdlow, input logic [15:0] rdsamp);
      write_reg(CSR_IDLE, idle);
      write_reg(CSR_RST_LOW, rlow);
      write_reg(CSR_PRES_SAMP, psamp);
      write_reg(CSR_RST_REC, rrec);
      write_reg(CSR_WR_LOW, wlow);
      write_reg(CSR_SLOT_TAIL, tail);
      write_reg(CSR_RD_LOW, rdlow);
      write_reg(CSR_RD_SAMP, rdsamp);
      end_writes();
   endtask

   initial begin
      int goal;
      bit paused;
      logic [15:0] target;
      logic [2:0] kind;

      timing = '{16'd1000, 16'd480, 16'd60, 16'd240, 16'd15, 16'd45, 16'd1, 16'd13};
      chk_state = '{PH_IDLE, 16'd0, 3'd0, 8'd0, 4'd0, 8'd0, 2'd0, 17'd0, 8'd0};
      plan_state = chk_state;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // plain and unknown requests while idle
      push_word(REQ_TICK, 8'h00, 1'b1);
      push_word(REQ_SPARE_A, 8'hFF, 1'b0);
      push_word(REQ_SPARE_A + 3'd1, 8'h55, 1'b1);
      push_word(REQ_SPARE_C, 8'hAA, 1'b0);
      wait_drained();

      // read slot low and sample times at their reset values;
      // writes to indexes that do not exist change nothing
      write_reg(CSR_IDLE, 16'd0);
      write_reg(CSR_SLOT_TAIL, 16'd0);
      write_reg(CSR_UNUSED_LO, 16'hFFFF);
      write_reg(CSR_UNUSED_HI, 16'h5A5A);
      end_writes();
      run_cmd(REQ_READ, 8'h00, DEV_PRESENT, 16'h005A, 2);
      wait_drained();

      // random command streams, one timing setting and idling mix per round
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
               load_timing(16'($urandom_range(2)), 16'($urandom_range(2)),
                           16'($urandom_range(2)), 16'($urandom_range(2)),
                           16'($urandom_range(2)), 16'($urandom_range(2)),
                           16'($urandom_range(2)), 16'($urandom_range(2)));
            end
            1: begin
               send_idle_pct = 76;
               recv_stall_pct = 0;
               load_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 76;
               load_timing(16'($urandom_range(1)), 16'($urandom_range(1)),
                           16'($urandom_range(1)), 16'($urandom_range(1)),
                           16'($urandom_range(1)), 16'($urandom_range(1)),
                           16'($urandom_range(1)), 16'($urandom_range(1)));
            end
            default: begin
               send_idle_pct = 29;
               recv_stall_pct = 29;
               load_timing(16'($urandom_range(3, 1)), 16'($urandom_range(1)),
                           16'($urandom_range(1)), 16'($urandom_range(1)),
                           16'($urandom_range(1)), 16'($urandom_range(1)),
                           16'($urandom_range(1)), 16'($urandom_range(1)));
            end
         endcase
         goal = pushed + RANDOM_WORDS / 4;
         paused = 1'b0;
         while (pushed < goal) begin
            // hold the sender once per round until everything is back
            if (!paused && pushed >= goal - RANDOM_WORDS / 8) begin
               wait_drained();
               paused = 1'b1;
            end
            case ($urandom_range(7))
               0: target = 16'h8000;
               1: target = 16'h7FFF;
               2: target = 16'hFFFF;
               3: target = 16'h0000;
               4: target = 16'hFE6F;
               default: target = 16'($urandom);
            endcase
            kind = 3'($urandom_range(REQ_TEMP, REQ_RESET));
            run_cmd(kind, 8'($urandom), DEV_PRESENT, target,
                    ($urandom_range(2) == 0) ? 0 : int'($urandom_range(20, 1)));
            repeat ($urandom_range(2)) idle_word();
         end
         wait_drained();
      end

      // no presence pulse: the temperature read is aborted and the last reading stays
      send_idle_pct = 29;
      recv_stall_pct = 29;
      load_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_cmd(REQ_TEMP, 8'h00, DEV_ABSENT, 16'h1234, 5);
      // the next reset clears both flags again
      run_cmd(REQ_RESET, 8'h00, DEV_PRESENT, 16'h0000, 0);
      wait_drained();

      repeat (8) @(posedge clock);
      if (error_count == 0 && predicted_rsp.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
